// ----- src/matrix_row_col_sum_swap_engine_unit_defines.svh -----
// Assertion helpers for the matrix engine.
`ifndef MATRIX_ROW_COL_SUM_SWAP_ENGINE_UNIT_DEFINES_SVH
`define MATRIX_ROW_COL_SUM_SWAP_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MRCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mrcs: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MRCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mrcs: next-cycle check failed");

`endif

// ----- src/mrcs_pkg.sv -----
package mrcs_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int KIND_W   = 3;
    localparam int IDX_W    = 6;
    localparam int DATA_W   = 32;
    localparam int TOTAL_W  = 38;
    localparam int ACC_W    = 40;
    localparam int CFG_W    = 7;
    localparam int CNT_W    = CFG_W;
    localparam int LIM_W    = 9;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        K_WRITE     = 3'd0,
        K_READ      = 3'd1,
        K_ROW_SUM   = 3'd2,
        K_COL_SUM   = 3'd3,
        K_SWAP_ROWS = 3'd4,
        K_SWAP_COLS = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        WR_ELEM = 2'd0,
        WR_A    = 2'd1,
        WR_B    = 2'd2
    } t_wr_sel;

    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic             acc_en;
        logic             wr_en;
        t_wr_sel          wr_sel;
        logic [CNT_W-1:0] rd_idx;
        logic [CNT_W-1:0] wr_idx;
        logic             res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              err;
        logic              same;
        logic [CFG_W-1:0]  line_len;
        logic              out_free;
    } t_dp_stat;

endpackage

// ----- src/matrix_row_col_sum_swap_engine_unit.sv -----
// Matrix engine holding MAX_ROWS x MAX_COLS signed 32-bit elements in one
// memory with one write port and two registered read ports. Each input
// transaction (kind on tuser) writes or reads an element, sums a row or a
// column exactly, or swaps two rows or two columns; each gives one output
// transaction with a status flag on tuser. The controller handles one
// transaction at a time. An error, a write, a self-swap, or a sum or swap
// over zero elements goes straight to its result; a read waits for the read
// port; a line sum reads each element of the line; a swap writes both lines
// at each position. Lines are the live column count long for row work and
// the live row count long for column work. The controller waits while the
// previous result still sits in the output register. Sums stream one element
// per cycle from a read port. The length of a swap is set by the single write
// port, which stores two elements per position. A finished result sits in an
// output register, so the next transaction is taken while it waits. Elements
// hold no reset value; read them only after writing. The user must write size
// registers only while the engine is idle; the block does not enforce this.
`include "matrix_row_col_sum_swap_engine_unit_defines.svh"

module matrix_row_col_sum_swap_engine_unit #(
    parameter int MAX_ROWS = mrcs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mrcs_pkg::DEF_MAX_COLS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [5:0] first_index, [11:6] second_index, [43:12] value, [47:44] zero
    input  logic [mrcs_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // [2:0] kind
    input  logic [mrcs_pkg::KIND_W-1:0]          i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [31:0] read_value, [69:32] line_total, [71:70] zero
    output logic [mrcs_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // [0] status
    output logic [0:0]                           o_m_tuser,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_idx,
    input  logic [mrcs_pkg::CFG_W-1:0]           i_cfg_data
);
    import mrcs_pkg::*;

    logic [CFG_W-1:0]         r_rows;
    logic [CFG_W-1:0]         r_cols;
    logic [CFG_W-1:0]         w_live_rows;
    logic [CFG_W-1:0]         w_live_cols;
    t_dp_cmd                  w_cmd;
    t_dp_stat                 w_stat;
    logic                     w_status;
    logic signed [DATA_W-1:0] w_read_value;
    logic signed [TOTAL_W-1:0] w_line_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_RESET;
            r_cols <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default:  r_rows <= r_rows;
            endcase
        end
    end

    // sizes above the built maximum act as the maximum
    assign w_live_rows = ({2'b00, r_rows} > LIM_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : r_rows;
    assign w_live_cols = ({2'b00, r_cols} > LIM_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : r_cols;

    mrcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mrcs_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_s_tuser),
        .i_first_index  (i_s_tdata[5:0]),
        .i_second_index (i_s_tdata[11:6]),
        .i_value        (i_s_tdata[43:12]),
        .i_live_rows    (w_live_rows),
        .i_live_cols    (w_live_cols),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_status       (w_status),
        .o_read_value   (w_read_value),
        .o_line_total   (w_line_total)
    );

    assign o_m_tdata = {2'b00, w_line_total, w_read_value};
    assign o_m_tuser = w_status;

    `MRCS_ASSERT_NOW(a_no_write_on_load, i_clk, i_rst_n, w_cmd.load, !w_cmd.wr_en)
    `MRCS_ASSERT_NOW(a_no_write_on_error, i_clk, i_rst_n, w_cmd.wr_en, !w_stat.err)
    `MRCS_ASSERT_NOW(a_result_when_busy, i_clk, i_rst_n, w_cmd.res_load, !o_s_tready)
    `MRCS_ASSERT_NEXT(a_result_shows, i_clk, i_rst_n, w_cmd.res_load, o_m_tvalid)

endmodule

// ----- src/mrcs_ctrl.sv -----
module mrcs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  mrcs_pkg::t_dp_stat i_stat,
    output mrcs_pkg::t_dp_cmd  o_cmd
);
    import mrcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_WAIT, S_SUM, S_DRAIN,
        S_SW_RD, S_SW_WA, S_SW_WB, S_SW_TAIL, S_DONE
    } t_state;

    t_state           r_state;
    logic             r_rd_en;
    logic             r_acc_en;
    logic             r_wr_en;
    t_wr_sel          r_wr_sel;
    logic [CNT_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] r_wr_idx;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W:0]   w_cnt_inc;

    assign w_cnt_inc  = {1'b0, r_cnt} + 1'b1;
    assign o_s_tready = (r_state == S_IDLE);

    assign o_cmd.load     = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.rd_en    = r_rd_en;
    assign o_cmd.acc_en   = r_acc_en;
    assign o_cmd.wr_en    = r_wr_en;
    assign o_cmd.wr_sel   = r_wr_sel;
    assign o_cmd.rd_idx   = r_rd_idx;
    assign o_cmd.wr_idx   = r_wr_idx;
    assign o_cmd.res_load = (r_state == S_DONE) && i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_en  <= 1'b0;
            r_acc_en <= 1'b0;
            r_wr_en  <= 1'b0;
            r_wr_sel <= WR_ELEM;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_cnt    <= '0;
        end else begin
            // commands last one cycle unless set again below
            r_rd_en  <= 1'b0;
            r_acc_en <= 1'b0;
            r_wr_en  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_cnt <= '0;
                    if (i_stat.err) begin
                        r_state <= S_DONE;
                    end else begin
                        unique case (i_stat.kind)
                            K_WRITE: begin
                                r_wr_en  <= 1'b1;
                                r_wr_sel <= WR_ELEM;
                                r_state  <= S_DONE;
                            end
                            K_READ: begin
                                r_rd_en  <= 1'b1;
                                r_rd_idx <= '0;
                                r_state  <= S_WAIT;
                            end
                            K_ROW_SUM, K_COL_SUM: begin
                                if (i_stat.line_len == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_rd_en  <= 1'b1;
                                    r_acc_en <= 1'b1;
                                    r_rd_idx <= '0;
                                    r_cnt    <= CNT_W'(1);
                                    r_state  <= S_SUM;
                                end
                            end
                            K_SWAP_ROWS, K_SWAP_COLS: begin
                                if (i_stat.same || i_stat.line_len == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_rd_en  <= 1'b1;
                                    r_rd_idx <= '0;
                                    r_state  <= S_SW_RD;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WAIT: begin
                    r_state <= S_DONE;
                end
                S_SUM: begin
                    if (r_cnt < i_stat.line_len) begin
                        r_rd_en  <= 1'b1;
                        r_acc_en <= 1'b1;
                        r_rd_idx <= r_cnt;
                        r_cnt    <= w_cnt_inc[CNT_W-1:0];
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_SW_RD: begin
                    r_wr_en  <= 1'b1;
                    r_wr_sel <= WR_A;
                    r_wr_idx <= r_cnt;
                    r_state  <= S_SW_WA;
                end
                S_SW_WA: begin
                    // write the second line and fetch the next position together
                    r_wr_en  <= 1'b1;
                    r_wr_sel <= WR_B;
                    r_wr_idx <= r_cnt;
                    if (w_cnt_inc < {1'b0, i_stat.line_len}) begin
                        r_rd_en  <= 1'b1;
                        r_rd_idx <= w_cnt_inc[CNT_W-1:0];
                        r_cnt    <= w_cnt_inc[CNT_W-1:0];
                        r_state  <= S_SW_WB;
                    end else begin
                        r_state <= S_SW_TAIL;
                    end
                end
                S_SW_WB: begin
                    r_wr_en  <= 1'b1;
                    r_wr_sel <= WR_A;
                    r_wr_idx <= r_cnt;
                    r_state  <= S_SW_WA;
                end
                S_SW_TAIL: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/mrcs_dp.sv -----
module mrcs_dp #(
    parameter int MAX_ROWS = mrcs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mrcs_pkg::DEF_MAX_COLS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [mrcs_pkg::KIND_W-1:0]         i_kind,
    input  logic [mrcs_pkg::IDX_W-1:0]          i_first_index,
    input  logic [mrcs_pkg::IDX_W-1:0]          i_second_index,
    input  logic signed [mrcs_pkg::DATA_W-1:0]  i_value,
    input  logic [mrcs_pkg::CFG_W-1:0]          i_live_rows,
    input  logic [mrcs_pkg::CFG_W-1:0]          i_live_cols,
    input  mrcs_pkg::t_dp_cmd                   i_cmd,
    output mrcs_pkg::t_dp_stat                  o_stat,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic                                o_status,
    output logic signed [mrcs_pkg::DATA_W-1:0]  o_read_value,
    output logic signed [mrcs_pkg::TOTAL_W-1:0] o_line_total
);
    import mrcs_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = AW + 8;

    localparam logic signed [ACC_W-1:0] TOT_HI =
        {{(ACC_W-TOTAL_W+1){1'b0}}, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] TOT_LO =
        {{(ACC_W-TOTAL_W+1){1'b1}}, {(TOTAL_W-1){1'b0}}};

    function automatic logic [AW-1:0] f_addr(input logic [CNT_W-1:0] row,
                                             input logic [CNT_W-1:0] col);
        logic [PW-1:0] lin;
        lin = PW'(row) * PW'(MAX_COLS) + PW'(col);
        return lin[AW-1:0];
    endfunction

    logic [KIND_W-1:0]        r_kind;
    logic [IDX_W-1:0]         r_first;
    logic [IDX_W-1:0]         r_second;
    logic [DATA_W-1:0]        r_value;
    logic [DATA_W-1:0]        r_mem [DEPTH];
    logic [DATA_W-1:0]        r_rd_a;
    logic [DATA_W-1:0]        r_rd_b;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_acc_pend;
    logic                     r_out_valid;
    logic                     r_out_status;
    logic [DATA_W-1:0]        r_out_read;
    logic [TOTAL_W-1:0]       r_out_total;

    logic [CNT_W-1:0]         w_a;
    logic [CNT_W-1:0]         w_b;
    logic                     w_a_row, w_b_row, w_a_col, w_b_col;
    logic                     w_err;
    logic [AW-1:0]            w_rd_addr_a;
    logic [AW-1:0]            w_rd_addr_b;
    logic [AW-1:0]            w_wr_addr;
    logic [DATA_W-1:0]        w_wr_data;
    logic [CNT_W-1:0]         w_wr_line;
    logic [TOTAL_W-1:0]       w_total;

    assign w_a = {1'b0, r_first};
    assign w_b = {1'b0, r_second};
    assign w_a_row = w_a < i_live_rows;
    assign w_b_row = w_b < i_live_rows;
    assign w_a_col = w_a < i_live_cols;
    assign w_b_col = w_b < i_live_cols;

    always_comb begin
        unique case (r_kind)
            K_WRITE, K_READ: w_err = !(w_a_row && w_b_col);
            K_ROW_SUM:       w_err = !w_a_row;
            K_COL_SUM:       w_err = !w_a_col;
            K_SWAP_ROWS:     w_err = !(w_a_row && w_b_row);
            K_SWAP_COLS:     w_err = !(w_a_col && w_b_col);
            default:         w_err = 1'b1;
        endcase
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.err      = w_err;
    assign o_stat.same     = (r_first == r_second);
    assign o_stat.line_len = (r_kind == K_COL_SUM || r_kind == K_SWAP_COLS)
                             ? i_live_rows : i_live_cols;
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    // read addresses: A walks line one, B line two; reads use A
    always_comb begin
        unique case (r_kind)
            K_ROW_SUM, K_SWAP_ROWS: begin
                w_rd_addr_a = f_addr(w_a, i_cmd.rd_idx);
                w_rd_addr_b = f_addr(w_b, i_cmd.rd_idx);
            end
            K_COL_SUM, K_SWAP_COLS: begin
                w_rd_addr_a = f_addr(i_cmd.rd_idx, w_a);
                w_rd_addr_b = f_addr(i_cmd.rd_idx, w_b);
            end
            default: begin
                w_rd_addr_a = f_addr(w_a, w_b);
                w_rd_addr_b = f_addr(w_b, i_cmd.rd_idx);
            end
        endcase
    end

    assign w_wr_line = (i_cmd.wr_sel == WR_A) ? w_a : w_b;

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_A:    w_wr_data = r_rd_b;
            WR_B:    w_wr_data = r_rd_a;
            default: w_wr_data = r_value;
        endcase
        if (i_cmd.wr_sel == WR_ELEM) begin
            w_wr_addr = f_addr(w_a, w_b);
        end else if (r_kind == K_SWAP_COLS) begin
            w_wr_addr = f_addr(i_cmd.wr_idx, w_wr_line);
        end else begin
            w_wr_addr = f_addr(w_wr_line, i_cmd.wr_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_first  <= i_first_index;
            r_second <= i_second_index;
            r_value  <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem[w_rd_addr_a];
            r_rd_b <= r_mem[w_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_pend <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_acc_pend <= i_cmd.rd_en && i_cmd.acc_en;
            if (i_cmd.load) begin
                r_acc <= '0;
            end else if (r_acc_pend) begin
                r_acc <= r_acc + {{(ACC_W-DATA_W){r_rd_a[DATA_W-1]}}, r_rd_a};
            end
        end
    end

    always_comb begin
        if (r_acc > TOT_HI) begin
            w_total = TOT_HI[TOTAL_W-1:0];
        end else if (r_acc < TOT_LO) begin
            w_total = TOT_LO[TOTAL_W-1:0];
        end else begin
            w_total = r_acc[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_status <= w_err;
            r_out_read   <= (r_kind == K_READ && !w_err) ? r_rd_a : '0;
            r_out_total  <= w_total;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_read;
    assign o_line_total = r_out_total;

endmodule
